FILE: sv/gfov_pkg.sv
package gfov_pkg;

   localparam int MAP_ROWS_DEF    = 64;
   localparam int MAP_COLS_DEF    = 64;
   localparam int VIEW_RADIUS_DEF = 15;

   // signed coordinate width, covers the grid plus the view box overhang
   localparam int COORD_W = 10;

   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_CLEAR   = 2'd2;
   localparam logic [1:0] OP_COMPUTE = 2'd3;

   typedef struct packed {
      logic tr_we;
      logic tr_wd;
      logic vis_we;
      logic vis_wd;
      logic seen_we;
      logic seen_wd;
   } mem_ctl_type;

   typedef struct packed {
      logic transparent;
      logic seen;
      logic visible;
   } map_bits_type;

endpackage

FILE: sv/grid_line_of_sight_fov.sv
// Tile grid with transparent, visible and seen bits and a Bresenham field-of-view
// engine. After reset the block sweeps the map memory clear, one tile a cycle,
// with req_tready low. A write goes from idle straight to the response, a read
// first passes a read state, and a view-box clear zeroes the visible bit of the
// interior tiles among the 4*VIEW_RADIUS^2 tiles of the view box. A view compute
// visits the same tiles one per cycle while no walk runs and, for each interior tile
// inside the radius, walks its line to the origin, each step being one read of the
// single transparency read port. Each beat gives exactly one result beat; a result
// may wait in the output register while the next beat is accepted.
module grid_line_of_sight_fov #(
   parameter int MAP_ROWS    = gfov_pkg::MAP_ROWS_DEF,
   parameter int MAP_COLS    = gfov_pkg::MAP_COLS_DEF,
   parameter int VIEW_RADIUS = gfov_pkg::VIEW_RADIUS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // opcode[1:0], row[7:2], col[13:8], transparent_in[14]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // visible_out[0], seen_out[1], transparent_out[2]
);

   localparam int AW = $clog2(MAP_ROWS * MAP_COLS);

   logic [AW-1:0]          mem_addr;
   gfov_pkg::mem_ctl_type  mem_ctl;
   gfov_pkg::map_bits_type mem_rd;
   gfov_pkg::map_bits_type rsp_bits;

   gfov_ctrl #(
      .MAP_ROWS    (MAP_ROWS),
      .MAP_COLS    (MAP_COLS),
      .VIEW_RADIUS (VIEW_RADIUS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .opcode         (req_tdata[1:0]),
      .row            (req_tdata[7:2]),
      .col            (req_tdata[13:8]),
      .transparent_in (req_tdata[14]),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_bits       (rsp_bits),
      .mem_addr       (mem_addr),
      .mem_ctl        (mem_ctl),
      .mem_rd         (mem_rd)
   );

   gfov_map #(
      .MAP_ROWS (MAP_ROWS),
      .MAP_COLS (MAP_COLS)
   ) u_map (
      .clock (clock),
      .addr  (mem_addr),
      .ctl   (mem_ctl),
      .rd    (mem_rd)
   );

   assign rsp_tdata = {5'b0, rsp_bits.transparent, rsp_bits.seen, rsp_bits.visible};

endmodule

FILE: sv/gfov_map.sv
module gfov_map #(
   parameter int MAP_ROWS = gfov_pkg::MAP_ROWS_DEF,
   parameter int MAP_COLS = gfov_pkg::MAP_COLS_DEF
) (
   input  logic                                  clock,
   input  logic [$clog2(MAP_ROWS*MAP_COLS)-1:0]  addr,
   input  gfov_pkg::mem_ctl_type                 ctl,
   output gfov_pkg::map_bits_type                rd
);

   localparam int CELLS = MAP_ROWS * MAP_COLS;

   logic       tr_mem   [CELLS];
   logic [1:0] view_mem [CELLS];
   logic       tr_ff;
   logic [1:0] view_ff;

   always_ff @(posedge clock) begin
      if (ctl.tr_we) begin
         tr_mem[addr] <= ctl.tr_wd;
      end
      if (ctl.vis_we) begin
         view_mem[addr][1] <= ctl.vis_wd;
      end
      if (ctl.seen_we) begin
         view_mem[addr][0] <= ctl.seen_wd;
      end
      tr_ff   <= tr_mem[addr];
      view_ff <= view_mem[addr];
   end

   assign rd.transparent = tr_ff;
   assign rd.visible     = view_ff[1];
   assign rd.seen        = view_ff[0];

endmodule

FILE: sv/gfov_ctrl.sv
module gfov_ctrl #(
   parameter int MAP_ROWS    = gfov_pkg::MAP_ROWS_DEF,
   parameter int MAP_COLS    = gfov_pkg::MAP_COLS_DEF,
   parameter int VIEW_RADIUS = gfov_pkg::VIEW_RADIUS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [1:0]                            opcode,
   input  logic [5:0]                            row,
   input  logic [5:0]                            col,
   input  logic                                  transparent_in,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output gfov_pkg::map_bits_type                rsp_bits,
   output logic [$clog2(MAP_ROWS*MAP_COLS)-1:0]  mem_addr,
   output gfov_pkg::mem_ctl_type                 mem_ctl,
   input  gfov_pkg::map_bits_type                mem_rd
);

   localparam int CW    = gfov_pkg::COORD_W;
   localparam int AW    = $clog2(MAP_ROWS * MAP_COLS);
   localparam int CELLS = MAP_ROWS * MAP_COLS;
   localparam int DW    = 2 * CW;

   localparam logic signed [CW-1:0] RAD    = CW'(VIEW_RADIUS);
   localparam logic signed [CW-1:0] ROWS_C = CW'(MAP_ROWS);
   localparam logic signed [CW-1:0] COLS_C = CW'(MAP_COLS);
   localparam logic signed [CW-1:0] ONE_C  = CW'(1);
   localparam logic signed [DW-1:0] RAD_SQ = DW'(VIEW_RADIUS * VIEW_RADIUS);
   localparam logic [AW-1:0]        LAST_A = AW'(CELLS - 1);

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_RD    = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_WSTEP = 3'd4;
   localparam logic [2:0] ST_WCHK  = 3'd5;
   localparam logic [2:0] ST_MARK  = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   function automatic logic in_grid(logic signed [CW-1:0] y, logic signed [CW-1:0] x);
      return y >= 0 && y < ROWS_C && x >= 0 && x < COLS_C;
   endfunction

   function automatic logic interior(logic signed [CW-1:0] y, logic signed [CW-1:0] x);
      return y > 0 && y < ROWS_C - ONE_C && x > 0 && x < COLS_C - ONE_C;
   endfunction

   function automatic logic [AW-1:0] cell_addr(logic signed [CW-1:0] y,
                                                logic signed [CW-1:0] x);
      logic [AW-1:0] ya;
      logic [AW-1:0] xa;
      ya = AW'($unsigned(y));
      xa = AW'($unsigned(x));
      return AW'(ya * AW'(MAP_COLS) + xa);
   endfunction

   logic [2:0]             state_ff, state_in;
   logic [AW-1:0]          sweep_ff, sweep_in;
   logic                   clr_ff, clr_in;
   logic signed [CW-1:0]   oy_ff, oy_in, ox_ff, ox_in;
   logic signed [CW-1:0]   sy_ff, sy_in, sx_ff, sx_in;
   logic signed [CW-1:0]   wy_ff, wy_in, wx_ff, wx_in, wt_ff, wt_in;
   logic signed [CW-1:0]   maj_ff, maj_in, min_ff, min_in, cnt_ff, cnt_in;
   logic                   xneg_ff, xneg_in, yneg_ff, yneg_in, axgt_ff, axgt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   gfov_pkg::map_bits_type rsp_ff, rsp_in, pend_ff, pend_in;

   logic signed [CW-1:0] in_y, in_x, ddy, ddx, dx, dy, ax, ay, sxs, sys;
   logic signed [CW-1:0] ny, nx, nt;
   logic signed [DW-1:0] d2;
   logic                 last_cell, out_free;

   assign in_y = CW'(row);
   assign in_x = CW'(col);

   assign ddy = sy_ff - oy_ff;
   assign ddx = sx_ff - ox_ff;
   assign d2  = ddy * ddy + ddx * ddx;
   assign dy  = oy_ff - sy_ff;
   assign dx  = ox_ff - sx_ff;
   assign ay  = dy < 0 ? -dy : dy;
   assign ax  = dx < 0 ? -dx : dx;
   assign last_cell = (sy_ff == oy_ff + RAD - ONE_C) && (sx_ff == ox_ff + RAD - ONE_C);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   assign sxs = xneg_ff ? -ONE_C : ONE_C;
   assign sys = yneg_ff ? -ONE_C : ONE_C;

   // one Bresenham step from the current walk position
   always_comb begin
      ny = wy_ff;
      nx = wx_ff;
      nt = wt_ff;
      if (wt_ff >= 0) begin
         if (axgt_ff) ny = ny + sys;
         else         nx = nx + sxs;
         nt = nt - (maj_ff <<< 1);
      end
      if (axgt_ff) nx = nx + sxs;
      else         ny = ny + sys;
      nt = nt + (min_ff <<< 1);
   end

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      clr_in       = clr_ff;
      oy_in        = oy_ff;
      ox_in        = ox_ff;
      sy_in        = sy_ff;
      sx_in        = sx_ff;
      wy_in        = wy_ff;
      wx_in        = wx_ff;
      wt_in        = wt_ff;
      maj_in       = maj_ff;
      min_in       = min_ff;
      cnt_in       = cnt_ff;
      xneg_in      = xneg_ff;
      yneg_in      = yneg_ff;
      axgt_in      = axgt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      pend_in      = pend_ff;
      mem_addr     = cell_addr(sy_ff, sx_ff);
      mem_ctl      = '0;
      req_tready   = 1'b0;

      unique case (state_ff)
         ST_INIT: begin
            mem_addr         = sweep_ff;
            mem_ctl.tr_we    = 1'b1;
            mem_ctl.vis_we   = 1'b1;
            mem_ctl.seen_we  = 1'b1;
            sweep_in         = sweep_ff + AW'(1);
            if (sweep_ff == LAST_A) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            mem_addr   = cell_addr(in_y, in_x);
            oy_in      = in_y;
            ox_in      = in_x;
            sy_in      = in_y - RAD;
            sx_in      = in_x - RAD;
            pend_in    = '0;
            if (req_tvalid) begin
               unique case (opcode)
                  gfov_pkg::OP_WRITE: begin
                     mem_ctl.tr_we = in_grid(in_y, in_x);
                     mem_ctl.tr_wd = transparent_in;
                     state_in      = ST_DONE;
                  end
                  gfov_pkg::OP_READ: begin
                     state_in = in_grid(in_y, in_x) ? ST_RD : ST_DONE;
                  end
                  gfov_pkg::OP_CLEAR: begin
                     clr_in   = 1'b1;
                     state_in = ST_SCAN;
                  end
                  default: begin
                     clr_in = 1'b0;
                     if (in_grid(in_y, in_x)) begin
                        mem_ctl.vis_we  = 1'b1;
                        mem_ctl.vis_wd  = 1'b1;
                        mem_ctl.seen_we = 1'b1;
                        mem_ctl.seen_wd = 1'b1;
                        state_in        = ST_SCAN;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
               endcase
            end
         end
         ST_RD: begin
            pend_in  = mem_rd;
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            if (clr_ff) begin
               mem_ctl.vis_we = interior(sy_ff, sx_ff);
               mem_ctl.vis_wd = 1'b0;
            end
            if (!clr_ff && d2 < RAD_SQ && interior(sy_ff, sx_ff)) begin
               wy_in   = sy_ff;
               wx_in   = sx_ff;
               xneg_in = dx < 0;
               yneg_in = dy < 0;
               axgt_in = ax > ay;
               maj_in  = ax > ay ? ax : ay;
               min_in  = ax > ay ? ay : ax;
               wt_in   = ((ax > ay ? ay : ax) <<< 1) - (ax > ay ? ax : ay);
               cnt_in  = '0;
               state_in = (dx == 0 && dy == 0) ? ST_MARK : ST_WSTEP;
            end else if (last_cell) begin
               state_in = ST_DONE;
            end else if (sx_ff == ox_ff + RAD - ONE_C) begin
               sx_in = ox_ff - RAD;
               sy_in = sy_ff + ONE_C;
            end else begin
               sx_in = sx_ff + ONE_C;
            end
         end
         ST_WSTEP: begin
            mem_addr = cell_addr(ny, nx);
            if (cnt_ff != maj_ff && nx == ox_ff && ny == oy_ff) begin
               state_in = ST_MARK;
            end else if (cnt_ff != maj_ff && in_grid(ny, nx)) begin
               wy_in    = ny;
               wx_in    = nx;
               wt_in    = nt;
               cnt_in   = cnt_ff + ONE_C;
               state_in = ST_WCHK;
            end else if (last_cell) begin
               state_in = ST_DONE;
            end else if (sx_ff == ox_ff + RAD - ONE_C) begin
               sx_in    = ox_ff - RAD;
               sy_in    = sy_ff + ONE_C;
               state_in = ST_SCAN;
            end else begin
               sx_in    = sx_ff + ONE_C;
               state_in = ST_SCAN;
            end
         end
         ST_WCHK: begin
            if (mem_rd.transparent) begin
               state_in = ST_WSTEP;
            end else if (last_cell) begin
               state_in = ST_DONE;
            end else if (sx_ff == ox_ff + RAD - ONE_C) begin
               sx_in    = ox_ff - RAD;
               sy_in    = sy_ff + ONE_C;
               state_in = ST_SCAN;
            end else begin
               sx_in    = sx_ff + ONE_C;
               state_in = ST_SCAN;
            end
         end
         ST_MARK: begin
            mem_ctl.vis_we  = 1'b1;
            mem_ctl.vis_wd  = 1'b1;
            mem_ctl.seen_we = 1'b1;
            mem_ctl.seen_wd = 1'b1;
            if (last_cell) begin
               state_in = ST_DONE;
            end else if (sx_ff == ox_ff + RAD - ONE_C) begin
               sx_in    = ox_ff - RAD;
               sy_in    = sy_ff + ONE_C;
               state_in = ST_SCAN;
            end else begin
               sx_in    = sx_ff + ONE_C;
               state_in = ST_SCAN;
            end
         end
         default: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_ff;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      clr_ff  <= clr_in;
      oy_ff   <= oy_in;
      ox_ff   <= ox_in;
      sy_ff   <= sy_in;
      sx_ff   <= sx_in;
      wy_ff   <= wy_in;
      wx_ff   <= wx_in;
      wt_ff   <= wt_in;
      maj_ff  <= maj_in;
      min_ff  <= min_in;
      cnt_ff  <= cnt_in;
      xneg_ff <= xneg_in;
      yneg_ff <= yneg_in;
      axgt_ff <= axgt_in;
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_bits   = rsp_ff;

endmodule

FILE: sv/gfov_checker.sv
module gfov_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:3] == 5'b0)
      else $error("rsp pad bits set");

   a_sweep: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("req accepted during map clear");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second beat accepted before first finished");

endmodule

bind grid_line_of_sight_fov gfov_checker u_gfov_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
